// File: src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// Battery state monitor package
// Shared types, state codes and constants for the battery state monitor.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned MaxCellsDefault = 8;
  localparam int unsigned PresentLevel    = 10;
  localparam int unsigned Hyst            = 10;
  localparam int unsigned FullMargin      = 7;
  localparam int unsigned AdcFullScale    = 32'hFFF * 10;
  localparam int unsigned VoltMul         = 33;
  localparam int unsigned CapMax          = 32'hFFFF;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 16;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_OK     = 2'd1,
    ST_WARN   = 2'd2,
    ST_CRIT   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VSCALE   = 3'd0,
    REG_CELL_MAX = 3'd1,
    REG_CELL_MIN = 3'd2,
    REG_CELL_WRN = 3'd3,
    REG_CAP_TOT  = 3'd4,
    REG_CAP_WRN  = 3'd5,
    REG_CAP_CRIT = 3'd6,
    REG_CAP_UNIT = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_VBAT,
    SQ_CELLS,
    SQ_THRESH,
    SQ_STATUS,
    SQ_PCT,
    SQ_OUT
  } seq_e;

  typedef struct packed {
    logic [11:0]        raw_sample;
    logic [11:0]        filtered_sample;
    logic signed [31:0] drawn_mah;
    logic signed [31:0] drawn_mwh;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  battery_status;
    logic [3:0]  cell_total;
    logic [9:0]  battery_voltage;
    logic [6:0]  charge_percent;
    logic [15:0] capacity_left;
    logic        full_at_connect;
  } out_beat_t;

  // Handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [17:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: src/bsm_div.sv
// ----------------------------------------------------------------------------
// Battery state monitor serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsm_pkg::div_req_t req_i,
  output bsm_pkg::div_rsp_t rsp_o
);
  import bsm_pkg::*;

  logic [31:0] quo_q, quo_d;
  logic [18:0] rem_q, rem_d;
  logic [17:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [18:0] trial;
  logic [18:0] shifted;

  // One shift and trial subtraction per cycle.
  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[17:0], quo_q[31]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[18]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// File: src/battery_state_monitor.sv
// ----------------------------------------------------------------------------
// Battery state monitor
// Tracks battery presence, cell count, charge state and remaining charge.
// ----------------------------------------------------------------------------
// Usage: one input beat carries raw and filtered ADC samples and the drawn
// mAh and mWh counts; each input beat gives exactly one output beat with
// status, cell count, voltage, percentage, remaining capacity and full flag.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while the block is idle; they take effect on the next beat.
// Sequence: the voltage is always divided; the percentage is divided too
// while a battery is present, but not while none is present or when it is
// removed. Every division runs through one shared bit-serial divider: the
// voltage and the percentage take one each, the cell count at connection
// with a nonzero cell maximum takes two.
// One beat is processed at a time; in_ready_o is high only while the
// sequencer is idle, so the next beat is taken only after the result has
// been delivered and the sequencer has returned to idle.
// Reset clears status to absent, cells to one, thresholds and flags to zero
// and loads the register defaults.
// If the receiver stalls, the result waits in the output register and the
// next input beat is not taken until it has been delivered.
module battery_state_monitor #(
  parameter int unsigned MaxCells = bsm_pkg::MaxCellsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsm_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bsm_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bsm_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bsm_pkg::out_beat_t                  out_data_o
);
  import bsm_pkg::*;

  // Configuration registers.
  logic [7:0]  vscale_q;
  logic [8:0]  cmax_q, cmin_q, cwrn_q;
  logic [15:0] ctot_q, cwrnc_q, ccrit_q;
  logic        cunit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vscale_q <= 8'd110;
      cmax_q   <= 9'd421;
      cmin_q   <= 9'd330;
      cwrn_q   <= 9'd350;
      ctot_q   <= '0;
      cwrnc_q  <= '0;
      ccrit_q  <= '0;
      cunit_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_VSCALE:   vscale_q <= cfg_data_i[7:0];
        REG_CELL_MAX: cmax_q   <= cfg_data_i[8:0];
        REG_CELL_MIN: cmin_q   <= cfg_data_i[8:0];
        REG_CELL_WRN: cwrn_q   <= cfg_data_i[8:0];
        REG_CAP_TOT:  ctot_q   <= cfg_data_i;
        REG_CAP_WRN:  cwrnc_q  <= cfg_data_i;
        REG_CAP_CRIT: ccrit_q  <= cfg_data_i;
        REG_CAP_UNIT: cunit_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Monitor state.
  status_e     st_q, st_d;
  logic [3:0]  cells_q, cells_d;
  logic [11:0] fth_q, fth_d, wth_q, wth_d, cth_q, cth_d;
  logic        wfull_q, wfull_d, ucap_q, ucap_d;
  logic [15:0] rem_q, rem_d;
  seq_e        sq_q, sq_d;
  in_beat_t    in_q;
  logic [9:0]  vbat_q, vbat_d;
  logic [6:0]  pct_q, pct_d;
  logic        vstep_q, vstep_d;   // second divide of the cell count step
  logic        outv_q, outv_d;
  out_beat_t   out_q, out_d;

  div_req_t req;
  div_rsp_t rsp;

  bsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Shared values for the current beat.
  logic signed [32:0] drawn;
  logic [16:0]        drawn_c;
  logic signed [19:0] rem_calc;
  logic [15:0]        rem_clamped;
  logic [15:0]        cap_span;
  logic               cap_pct;
  logic signed [13:0] v_span;
  logic signed [13:0] v_num;
  logic signed [17:0] c_num;
  logic [20:0]        vprod;

  always_comb begin
    drawn   = cunit_q ? 33'(in_q.drawn_mwh) : 33'(in_q.drawn_mah);
    drawn_c = drawn < 0 ? 17'd0 : (drawn > 33'sd65535 ? 17'd65535 : 17'(drawn));
    rem_calc    = 20'sd0;
    rem_clamped = '0;
    if (drawn < -33'sd200000)
      rem_clamped = 16'hFFFF;
    else if (drawn > 33'sd200000)
      rem_clamped = '0;
    else begin
      rem_calc = $signed({4'b0, ctot_q}) - $signed({4'b0, ccrit_q}) - 20'(drawn);
      rem_clamped = rem_calc < 0 ? 16'd0 :
                    (rem_calc > 20'sd65535 ? 16'hFFFF : rem_calc[15:0]);
    end
    cap_span = ctot_q - ccrit_q;
    cap_pct  = wfull_q && ctot_q != 0 && ccrit_q != 0;
    v_span   = $signed({2'b0, fth_q}) - $signed({2'b0, cth_q});
    v_num    = $signed({4'b0, vbat_q}) - $signed({2'b0, cth_q});
    c_num    = $signed({1'b0, cap_span}) - $signed({1'b0, drawn_c});
    vprod    = 21'(in_data_i.filtered_sample) * 21'(vscale_q);
  end

  // Sequencer next state.
  always_comb begin
    sq_d = sq_q;
    case (sq_q)
      SQ_IDLE:   if (in_valid_i && in_ready_o) sq_d = SQ_VBAT;
      SQ_VBAT:   if (rsp.done) sq_d = SQ_CELLS;
      SQ_CELLS:  if (st_q != ST_ABSENT || vbat_q <= 10'(PresentLevel) || cmax_q == 0 ||
                     (vstep_q && rsp.done)) sq_d = SQ_THRESH;
      SQ_THRESH: sq_d = SQ_STATUS;
      SQ_STATUS: sq_d = SQ_PCT;
      SQ_PCT:    if (st_q == ST_ABSENT || rsp.done) sq_d = SQ_OUT;
      SQ_OUT:    if (!outv_q) sq_d = SQ_IDLE;
      default:   sq_d = SQ_IDLE;
    endcase
  end

  // Sequencer datapath actions.
  always_comb begin
    logic [35:0] q;
    logic [31:0] cfull;
    logic signed [13:0] vb;
    q       = '0;
    cfull   = '0;
    vb      = $signed({4'b0, vbat_q});
    st_d    = st_q;
    cells_d = cells_q;
    fth_d   = fth_q;
    wth_d   = wth_q;
    cth_d   = cth_q;
    wfull_d = wfull_q;
    ucap_d  = ucap_q;
    rem_d   = rem_q;
    vbat_d  = vbat_q;
    pct_d   = pct_q;
    vstep_d = vstep_q;
    outv_d  = outv_q;
    out_d   = out_q;
    req     = '0;
    if (outv_q && out_ready_i) outv_d = 1'b0;
    case (sq_q)
      SQ_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          // Filtered sample to centivolts, scaled product times 33.
          req.start    = 1'b1;
          req.dividend = 32'(vprod) * 32'(VoltMul);
          req.divisor  = 18'(AdcFullScale);
          vstep_d      = 1'b0;
        end
      end
      SQ_VBAT: begin
        if (rsp.done) begin
          vbat_d = rsp.quotient[9:0];
          if (st_q == ST_ABSENT && rsp.quotient[9:0] > 10'(PresentLevel) && cmax_q != 0) begin
            req.start    = 1'b1;
            req.dividend = 32'(21'(in_q.raw_sample) * 21'(vscale_q)) * 32'(VoltMul);
            req.divisor  = 18'(AdcFullScale);
          end
        end
      end
      SQ_CELLS: begin
        if (st_q == ST_ABSENT && vbat_q > 10'(PresentLevel)) begin
          if (cmax_q == 0) begin
            cells_d = 4'(MaxCells);
          end else if (rsp.done && !vstep_q) begin
            vstep_d      = 1'b1;
            req.start    = 1'b1;
            req.dividend = rsp.quotient;
            req.divisor  = 18'(cmax_q);
          end else if (rsp.done && vstep_q) begin
            q = 36'(rsp.quotient) + 36'd1;
            cells_d = q > 36'(MaxCells) ? 4'(MaxCells) : q[3:0];
          end
        end else if (st_q != ST_ABSENT && vbat_q <= 10'(PresentLevel)) begin
          st_d    = ST_ABSENT;
          cells_d = '0;
          wth_d   = '0;
          cth_d   = '0;
        end
      end
      SQ_THRESH: begin
        if (st_q == ST_ABSENT && vbat_q > 10'(PresentLevel)) begin
          st_d  = ST_OK;
          cfull = 32'(cells_q) * 32'(cmax_q);
          fth_d = cfull[11:0];
          cfull = 32'(cells_q) * 32'(cwrn_q);
          wth_d = cfull[11:0];
          cfull = 32'(cells_q) * 32'(cmin_q);
          cth_d = cfull[11:0];
          wfull_d = vb >= $signed({2'b0, fth_d}) - $signed(14'(cells_q) * 14'sd7);
          ucap_d  = wfull_d && ctot_q != 0 && cwrnc_q != 0 && ccrit_q != 0;
        end
      end
      SQ_STATUS: begin
        pct_d = '0;
        if (st_q != ST_ABSENT) begin
          if (ctot_q != 0 && wfull_q) rem_d = rem_clamped;
          if (ucap_q) begin
            if (rem_d == 0) st_d = ST_CRIT;
            else if ($signed({3'b0, rem_d}) <=
                     $signed({3'b0, cwrnc_q}) - $signed({3'b0, ccrit_q}))
              st_d = ST_WARN;
          end else begin
            case (st_q)
              ST_OK:   if (vb <= $signed({2'b0, wth_q}) - 14'sd10) st_d = ST_WARN;
              ST_WARN: begin
                if (vb <= $signed({2'b0, cth_q}) - 14'sd10) st_d = ST_CRIT;
                else if (vb > $signed({2'b0, wth_q}) + 14'sd10) st_d = ST_OK;
              end
              default: if (vb > $signed({2'b0, cth_q}) + 14'sd10) st_d = ST_WARN;
            endcase
          end
          // Start the percentage divide; zero span or ratio <= 0 gives zero.
          if (cap_pct) begin
            if (cap_span != 0 && c_num > 0) begin
              req.start    = 1'b1;
              req.dividend = 32'(c_num) * 32'd100;
              req.divisor  = 18'(cap_span);
            end else begin
              req.start    = 1'b1;
              req.dividend = '0;
              req.divisor  = 18'd1;
            end
          end else if (v_span != 0 && v_num > 0 && v_span > 0) begin
            req.start    = 1'b1;
            req.dividend = 32'(v_num) * 32'd100;
            req.divisor  = 18'(v_span);
          end else begin
            // Negative span and numerator give a positive ratio; else zero.
            req.start    = 1'b1;
            req.dividend = (v_span < 0 && v_num < 0) ? 32'(-v_num) * 32'd100 : 32'd0;
            req.divisor  = (v_span < 0) ? 18'(-v_span) : 18'd1;
          end
        end
      end
      SQ_PCT: begin
        if (st_q != ST_ABSENT && rsp.done)
          pct_d = rsp.quotient > 32'd100 ? 7'd100 : rsp.quotient[6:0];
        if (st_q == ST_ABSENT || rsp.done) begin
          outv_d = 1'b1;
          out_d.battery_status  = st_q;
          out_d.cell_total      = cells_q;
          out_d.battery_voltage = vbat_q;
          out_d.charge_percent  = (st_q == ST_ABSENT) ? 7'd0 : pct_d;
          out_d.capacity_left   = rem_q;
          out_d.full_at_connect = wfull_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q    <= SQ_IDLE;
      st_q    <= ST_ABSENT;
      cells_q <= 4'd1;
      fth_q   <= '0;
      wth_q   <= '0;
      cth_q   <= '0;
      wfull_q <= 1'b0;
      ucap_q  <= 1'b0;
      rem_q   <= '0;
      outv_q  <= 1'b0;
      vstep_q <= 1'b0;
    end else begin
      sq_q    <= sq_d;
      st_q    <= st_d;
      cells_q <= cells_d;
      fth_q   <= fth_d;
      wth_q   <= wth_d;
      cth_q   <= cth_d;
      wfull_q <= wfull_d;
      ucap_q  <= ucap_d;
      rem_q   <= rem_d;
      outv_q  <= outv_d;
      vstep_q <= vstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    vbat_q <= vbat_d;
    pct_q  <= pct_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (sq_q == SQ_IDLE) && !outv_q;
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;
endmodule

// File: src/bsm_checker.sv
// ----------------------------------------------------------------------------
// Battery state monitor checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bsm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bsm_pkg::out_beat_t out_data_o
);
  import bsm_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // No new input while a result is pending.
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  // Percentage stays in range.
  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.charge_percent <= 7'd100)
    else $error("percentage out of range");

  // An absent battery reports zero percent.
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.battery_status == ST_ABSENT |->
      out_data_o.charge_percent == 7'd0)
    else $error("absent battery with nonzero percentage");
endmodule

bind battery_state_monitor bsm_checker u_bsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
